[rtl/polar_cartesian_converter_macros.svh]
// Assertion macros for the polar/rectangular converter.
// Every macro samples on clk_i and is disabled while rst_ni is low, so both
// signals must be in scope wherever a macro is used.
`ifndef POLAR_CARTESIAN_CONVERTER_MACROS_SVH
`define POLAR_CARTESIAN_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
// Next-cycle implication.
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPL(lbl, ante, cons)
`define PCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/pcc_pkg.sv]
// Shared types and constants of the polar/rectangular converter.
// No dependencies; the prep, cell, post and top modules of the block import this package.
`default_nettype none

package pcc_pkg;

  // Fraction bits carried by the internal coordinates.
  localparam int GUARD = 16;
  // Extra integer and fraction bits of an internal coordinate over DATA_WIDTH.
  localparam int COORD_EXTRA = 19;
  // Length of the arctangent table, which bounds the number of iterations.
  localparam int TAB_LEN = 24;

  // Converged CORDIC gain 0.6072529350 in Q31.
  localparam logic [30:0] K_Q31 = 31'd1304065748;

  // Phase of pi in 32-bit wrapping phase units (2^32 per turn).
  localparam logic [31:0] PHASE_PI      = 32'h8000_0000;
  localparam logic [31:0] PHASE_HALF_PI = 32'h4000_0000;
  localparam logic [31:0] PHASE_3HALF   = 32'hC000_0000;

  // atan(2^-i) in phase units, rounded to nearest.
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Control that travels with each request down the pipeline.
  typedef struct packed {
    logic valid;
    logic mode;    // 0: rectangular to polar, 1: polar to rectangular
    logic origin;  // rectangular request at (0, 0)
  } pcc_ctrl_t;

endpackage

`default_nettype wire

[rtl/pcc_in_if.sv]
// Request channel of the polar/rectangular converter: valid/ready and payload.
// No dependencies.
`default_nettype none

interface pcc_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [DATA_WIDTH-1:0] x_or_radius;
  logic signed [DATA_WIDTH-1:0] y_or_angle;

  modport source (output valid, mode, x_or_radius, y_or_angle, input ready);
  modport sink   (input valid, mode, x_or_radius, y_or_angle, output ready);
endinterface

`default_nettype wire

[rtl/pcc_out_if.sv]
// Result channel of the polar/rectangular converter: valid/ready and payload.
// No dependencies.
`default_nettype none

interface pcc_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [DATA_WIDTH:0] first_result;
  logic signed [DATA_WIDTH:0] second_result;

  modport source (output valid, first_result, second_result, input ready);
  modport sink   (input valid, first_result, second_result, output ready);
endinterface

`default_nettype wire

[rtl/pcc_prep.sv]
// Front end of the converter: gain pre-scale, quadrant fold and start values.
// Depends on pcc_pkg.
`default_nettype none

module pcc_prep #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic                         valid_i,
  input  wire logic                         mode_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_i,
  output pcc_pkg::pcc_ctrl_t                ctrl_o,
  output logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] x_o,
  output logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] y_o,
  output logic        [31:0]                z_o
);
  import pcc_pkg::*;

  localparam int CW = DATA_WIDTH + COORD_EXTRA;
  localparam int PW = DATA_WIDTH + 32;

  // Stage A: radius times gain.
  logic signed [31:0]           k_s;
  logic signed [PW-1:0]         prod_d, prod_q;
  logic signed [DATA_WIDTH-1:0] a_q, b_q;
  pcc_ctrl_t                    ctrl_a_d, ctrl_a_q;

  assign k_s    = $signed({1'b0, K_Q31});
  assign prod_d = PW'(a_i) * PW'(k_s);

  always_comb begin
    ctrl_a_d.valid  = valid_i;
    ctrl_a_d.mode   = mode_i;
    ctrl_a_d.origin = !mode_i && (a_i == '0) && (b_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
    end else if (adv_i) begin
      ctrl_a_q <= ctrl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      b_q    <= b_i;
    end
  end

  // Stage B: fold into the right half plane and form the start vector.
  logic signed [CW-1:0] xk, xa, yb, x_d, y_d;
  logic        [31:0]   phase_in, z_d;
  logic                 flip;

  always_comb begin
    xk       = CW'(prod_q >>> (31 - GUARD));
    phase_in = 32'(unsigned'(b_q)) << (32 - DATA_WIDTH);
    flip     = (phase_in > PHASE_HALF_PI) && (phase_in < PHASE_3HALF);
    xa       = CW'(a_q) <<< GUARD;
    yb       = CW'(b_q) <<< GUARD;
    if (ctrl_a_q.mode) begin
      // An angle beyond a quarter turn starts from the mirrored point.
      x_d = flip ? -xk : xk;
      y_d = '0;
      z_d = flip ? phase_in + PHASE_PI : phase_in;
    end else begin
      x_d = a_q[DATA_WIDTH-1] ? -xa : xa;
      y_d = a_q[DATA_WIDTH-1] ? -yb : yb;
      z_d = a_q[DATA_WIDTH-1] ? PHASE_PI : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (adv_i) begin
      ctrl_o <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pcc_cell.sv]
// One CORDIC micro-rotation with its pipeline register.
// Depends on pcc_pkg for the arctangent table and the control struct.
`default_nettype none

module pcc_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int STAGE      = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire pcc_pkg::pcc_ctrl_t  ctrl_i,
  input  wire logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] x_i,
  input  wire logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] y_i,
  input  wire logic        [31:0]  z_i,
  output pcc_pkg::pcc_ctrl_t       ctrl_o,
  output logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] x_o,
  output logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] y_o,
  output logic        [31:0]       z_o
);
  import pcc_pkg::*;

  localparam int          CW   = DATA_WIDTH + COORD_EXTRA;
  localparam logic [31:0] ATAN = ATAN_TAB[STAGE];

  logic                 ccw;
  logic signed [CW-1:0] xs, ys, x_d, y_d;
  logic        [31:0]   z_d;

  // Rotation drives the phase to zero, vectoring drives y to zero.
  assign ccw = ctrl_i.mode ? !z_i[31] : y_i[CW-1];
  assign xs  = x_i >>> STAGE;
  assign ys  = y_i >>> STAGE;

  always_comb begin
    if (ccw) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (adv_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pcc_post.sv]
// Back end of the converter: rounding, gain removal on the radius, output register.
// Depends on pcc_pkg and the pcc_out_if interface.
`default_nettype none

module pcc_post #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire pcc_pkg::pcc_ctrl_t  ctrl_i,
  input  wire logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] x_i,
  input  wire logic signed [DATA_WIDTH+pcc_pkg::COORD_EXTRA-1:0] y_i,
  input  wire logic        [31:0]  z_i,
  output pcc_pkg::pcc_ctrl_t       ctrl_o,
  pcc_out_if.source                out_o
);
  import pcc_pkg::*;

  localparam int CW = DATA_WIDTH + COORD_EXTRA;
  localparam int OW = DATA_WIDTH + 1;
  localparam int HW = CW - 25;
  localparam int HPW = HW + 31;
  localparam int SW = DATA_WIDTH + 50;
  localparam int RW = SW - 47;

  localparam logic signed [CW-1:0] ROUND_HALF = CW'(1 <<< (GUARD - 1));
  localparam logic signed [CW-1:0] OUT_MAX    = CW'((64'sd1 <<< DATA_WIDTH) - 64'sd1);
  localparam logic signed [CW-1:0] OUT_MIN    = CW'(-(64'sd1 <<< DATA_WIDTH));
  localparam logic        [RW-1:0] RAD_MAX    = RW'((64'd1 << DATA_WIDTH) - 64'd1);
  localparam logic        [31:0]   ANG_BIAS   =
    (DATA_WIDTH < 32) ? (32'd1 << (31 - DATA_WIDTH)) : 32'd0;
  localparam logic        [SW-1:0] SUM_HALF   = SW'(1) << 46;

  function automatic logic signed [OW-1:0] sat_out(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    c = v;
    if (v > OUT_MAX) begin
      c = OUT_MAX;
    end else if (v < OUT_MIN) begin
      c = OUT_MIN;
    end
    return OW'(c);
  endfunction

  // Stage C: round the rotated coordinates, round the phase, and form the two
  // partial products of the radius with the gain.
  logic signed [CW-1:0] x_rnd, y_rnd;
  logic        [31:0]   z_rnd;
  logic        [CW-2:0] mag;
  logic        [HW-1:0] hi;
  logic        [23:0]   lo;
  logic signed [OW-1:0] fr_d, sr_d, ang_d, fr_q, sr_q, ang_q;
  logic        [HPW-1:0] hi_p_d, hi_p_q;
  logic        [54:0]   lo_p_d, lo_p_q;
  pcc_ctrl_t            ctrl_c_q;

  always_comb begin
    x_rnd  = (x_i + ROUND_HALF) >>> GUARD;
    y_rnd  = (y_i + ROUND_HALF) >>> GUARD;
    fr_d   = sat_out(x_rnd);
    sr_d   = sat_out(y_rnd);
    z_rnd  = z_i + ANG_BIAS;
    ang_d  = OW'($signed(z_rnd[31 -: DATA_WIDTH]));
    // The vectoring x is never negative, so its sign bit is dropped.
    mag    = x_i[CW-2:0];
    hi     = mag[CW-2:24];
    lo     = mag[23:0];
    hi_p_d = HPW'(hi) * HPW'(K_Q31);
    lo_p_d = 55'(lo) * 55'(K_Q31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_c_q <= '0;
    end else if (adv_i) begin
      ctrl_c_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fr_q   <= fr_d;
      sr_q   <= sr_d;
      ang_q  <= ang_d;
      hi_p_q <= hi_p_d;
      lo_p_q <= lo_p_d;
    end
  end

  // Stage D: radius = round(floor(x * K / 2^31) / 2^16), folded into one shift.
  logic [SW-1:0]        sum;
  logic [RW-1:0]        rad;
  logic signed [OW-1:0] rad_s, first_d, second_d, first_q, second_q;
  pcc_ctrl_t            ctrl_q;

  always_comb begin
    sum   = (SW'(hi_p_q) << 24) + SW'(lo_p_q) + SUM_HALF;
    rad   = sum[SW-1:47];
    rad_s = (rad > RAD_MAX) ? OW'(RAD_MAX) : OW'(rad);
    if (ctrl_c_q.mode) begin
      first_d  = fr_q;
      second_d = sr_q;
    end else if (ctrl_c_q.origin) begin
      first_d  = '0;
      second_d = '0;
    end else begin
      first_d  = rad_s;
      second_d = ang_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign ctrl_o              = ctrl_q;
  assign out_o.valid         = ctrl_q.valid;
  assign out_o.first_result  = first_q;
  assign out_o.second_result = second_q;

endmodule

`default_nettype wire

[rtl/polar_cartesian_converter.sv]
// Polar/rectangular coordinate converter.
// Each request carries a mode bit and a coordinate pair. Mode 0 turns (x, y)
// into the radius and the four-quadrant angle, a signed fraction of pi.
// Mode 1 turns (radius, angle) into (x, y). The gain of the rotation chain is
// removed, and the results are one bit wider than the inputs.
// Requests enter on in_i and results leave on out_o, both valid/ready
// channels that move one request at a rising edge with valid and ready high.
// There are two front-end stages (gain multiply, then quadrant fold), one
// cell per iteration, and two back-end stages (rounding with the radius
// partial products, then the output register).
// Throughput is one request per cycle unless the receiver stalls, set by
// the chain of cells, each of which does one micro-rotation and hands its vector on.
// The pipeline moves as a whole: it advances whenever the output register is
// empty or its result is being taken, and in_i.ready follows that condition.
// While the receiver stalls with a result waiting, every stage holds.
// Reset clears the valid bits of all stages; data in flight is lost and none is
// produced by it, and the block takes requests in the first cycle after reset.
// The interfaces must be built with the same DATA_WIDTH as this module.
`default_nettype none

`include "polar_cartesian_converter_macros.svh"

module polar_cartesian_converter #(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcc_in_if.sink    in_i,
  pcc_out_if.source out_o
);
  import pcc_pkg::*;

  localparam int CW = DATA_WIDTH + COORD_EXTRA;

  logic                 adv;
  logic                 res_zero;
  pcc_ctrl_t            out_ctrl;
  pcc_ctrl_t            cctrl [ITERATIONS+1];
  logic signed [CW-1:0] cx    [ITERATIONS+1];
  logic signed [CW-1:0] cy    [ITERATIONS+1];
  logic        [31:0]   cz    [ITERATIONS+1];

  assign adv        = !out_ctrl.valid || out_o.ready;
  assign in_i.ready = adv;

  pcc_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(in_i.valid),
    .mode_i (in_i.mode),
    .a_i    (in_i.x_or_radius),
    .b_i    (in_i.y_or_angle),
    .ctrl_o (cctrl[0]),
    .x_o    (cx[0]),
    .y_o    (cy[0]),
    .z_o    (cz[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    pcc_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .STAGE     (i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctrl_i(cctrl[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .ctrl_o(cctrl[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  pcc_post #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_post (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .ctrl_i(cctrl[ITERATIONS]),
    .x_i   (cx[ITERATIONS]),
    .y_i   (cy[ITERATIONS]),
    .z_i   (cz[ITERATIONS]),
    .ctrl_o(out_ctrl),
    .out_o (out_o)
  );

  assign res_zero = (out_o.first_result == '0) && (out_o.second_result == '0);

  // A radius is never negative.
  `PCC_ASSERT_IMPL(a_radius_nonneg, out_o.valid && !out_ctrl.mode, !out_o.first_result[DATA_WIDTH])
  // A held output freezes the front of the chain.
  `PCC_ASSERT_NEXT(a_stall_freezes, !adv, $stable(cctrl[0]))
  // A rectangular request at the origin gives radius and angle of zero.
  `PCC_ASSERT_IMPL(a_origin_zero, out_o.valid && out_ctrl.origin, res_zero)

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench of polar_cartesian_converter: directed corner cases, then random
// coordinate pairs in both modes, with random idling, back-pressure and a drain pause.
// Depends on pcc_pkg, pcc_in_if, pcc_out_if and the converter RTL.
module tb;

  localparam int ITERATIONS = 16;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int LATENCY    = ITERATIONS + 4;
  localparam int NUM_ITEMS  = 1100;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic MODE_TO_POLAR = 1'b0;
  localparam logic MODE_TO_RECT  = 1'b1;

  localparam longint      GAIN_Q31      = 64'sd1304065748;
  localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;

  // atan(2^-i) as a 32-bit phase, one full turn being 2^32.
  localparam logic [31:0] ATAN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] coord_a;
    logic signed [DATA_WIDTH-1:0] coord_b;
    logic signed [DATA_WIDTH:0]   first;
    logic signed [DATA_WIDTH:0]   second;
  } conversion_t;

  class conversion_scoreboard;
    conversion_t pending_results[$];
    int          errors;
    int          accepted;
    int          checked_polar;
    int          checked_rect;

    function automatic logic signed [DATA_WIDTH:0] clamp_out(longint v);
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return v[DATA_WIDTH:0];
    endfunction

    function automatic longint round_coord(longint v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Fixed-point CORDIC conversion of one request, computed bit for bit.
    function automatic conversion_t convert(logic mode, logic signed [DATA_WIDTH-1:0] a,
                                            logic signed [DATA_WIDTH-1:0] b);
      conversion_t res;
      longint      x;
      longint      y;
      longint      nx;
      longint      z;
      logic [31:0] phase;
      logic [95:0] prod;
      logic [32:0] angle;
      res.mode = mode;
      res.coord_a = a;
      res.coord_b = b;
      if (mode == MODE_TO_RECT) begin
        phase = {b, 16'h0000};
        x = (longint'(a) * GAIN_Q31) >>> (31 - FRAC_BITS);
        y = 0;
        // Angles beyond a quarter turn are folded by a half turn and a sign flip.
        if (phase > QUARTER_TURN && phase < THREE_QUARTER) begin
          x = -x;
          phase = phase + HALF_TURN;
        end
        z = longint'(signed'(phase));
        for (int i = 0; i < ITERATIONS && i < 24; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ATAN_STEP[i]);
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ATAN_STEP[i]);
          end
          x = nx;
        end
        res.first = clamp_out(round_coord(x));
        res.second = clamp_out(round_coord(y));
      end else if (a == 0 && b == 0) begin
        res.first = '0;
        res.second = '0;
      end else begin
        x = longint'(a) * 65536;
        y = longint'(b) * 65536;
        phase = '0;
        if (x < 0) begin
          x = -x;
          y = -y;
          phase = HALF_TURN;
        end
        for (int i = 0; i < ITERATIONS && i < 24; i++) begin
          if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            phase = phase + ATAN_STEP[i];
          end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            phase = phase - ATAN_STEP[i];
          end
          x = nx;
        end
        // The magnitude times the gain needs more than 64 bits.
        prod = 96'(x) * 96'(GAIN_Q31);
        prod = prod >> 31;
        prod = (prod + 96'(32768)) >> FRAC_BITS;
        res.first = clamp_out(longint'(prod[62:0]));
        angle = {1'b0, phase} + 33'h0_0000_8000;
        angle = angle >> 16;
        res.second = {angle[15], angle[15:0]};
      end
      return res;
    endfunction

    function void note_request(logic mode, logic signed [DATA_WIDTH-1:0] a,
                               logic signed [DATA_WIDTH-1:0] b);
      pending_results.push_back(convert(mode, a, b));
      accepted++;
    endfunction

    function void check_result(logic signed [DATA_WIDTH:0] first,
                               logic signed [DATA_WIDTH:0] second);
      conversion_t exp_res;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result first=%0d second=%0d", $time, first, second);
        return;
      end
      exp_res = pending_results.pop_front();
      if (exp_res.mode == MODE_TO_RECT) checked_rect++;
      else checked_polar++;
      if (first !== exp_res.first) begin
        errors++;
        $display("%0t: mode %0d in (%0d, %0d) first_result expected %0d actual %0d", $time,
                 exp_res.mode, exp_res.coord_a, exp_res.coord_b, exp_res.first, first);
      end
      if (second !== exp_res.second) begin
        errors++;
        $display("%0t: mode %0d in (%0d, %0d) second_result expected %0d actual %0d", $time,
                 exp_res.mode, exp_res.coord_a, exp_res.coord_b, exp_res.second, second);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;
  bit   hold_done = 1'b0;
  int   cycles = 0;

  conversion_scoreboard sb = new();

  pcc_in_if  #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
  pcc_out_if #(.DATA_WIDTH(DATA_WIDTH)) res_if ();

  polar_cartesian_converter #(
    .ITERATIONS(ITERATIONS),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.first_result, res_if.second_result);
    end
  end

  // Receiver: random stalls, one long hold-off, and a stretch that never stalls.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.accepted >= 300) begin
        hold_done = 1'b1;
        res_if.ready = 1'b0;
        repeat (150) @(negedge clk_i);
      end
      res_if.ready = steady ? 1'b1 : ($urandom_range(0, 99) >= 29);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic mode, input logic signed [DATA_WIDTH-1:0] a,
                              input logic signed [DATA_WIDTH-1:0] b);
    req_if.valid = 1'b1;
    req_if.mode = mode;
    req_if.x_or_radius = a;
    req_if.y_or_angle = b;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(mode, a, b);
    @(negedge clk_i);
  endtask

  // Each cycle the sender idles with the same chance as the receiver.
  task automatic maybe_idle();
    while (!steady && $urandom_range(0, 99) < 29) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_WIDTH'($urandom);
      4, 5:       return DATA_WIDTH'($urandom_range(0, 80)) - 16'sd40;
      6:          return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      7:          return DATA_WIDTH'($urandom_range(0, 255)) + 16'sh7F00;
      8:          return DATA_WIDTH'($urandom_range(0, 255)) + 16'sh8000;
      default:    return DATA_WIDTH'($urandom_range(0, 2)) - 16'sd1;
    endcase
  endfunction

  // Angles near the quarter-turn folds, the half turn and zero get extra weight.
  function automatic logic signed [DATA_WIDTH-1:0] pick_angle();
    logic signed [DATA_WIDTH-1:0] jitter;
    jitter = DATA_WIDTH'($urandom_range(0, 6)) - 16'sd3;
    case ($urandom_range(0, 7))
      0: return 16'sh4000 + jitter;
      1: return 16'shC000 + jitter;
      2: return 16'sh8000 + jitter;
      3: return jitter;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_directed();
    // Rectangular to polar: origin, axes, the angle of pi, diagonals and extremes.
    send_request(MODE_TO_POLAR, 16'sd0, 16'sd0);
    send_request(MODE_TO_POLAR, 16'sh7FFF, 16'sd0);
    send_request(MODE_TO_POLAR, 16'sh8000, 16'sd0);
    send_request(MODE_TO_POLAR, -16'sd1, 16'sd0);
    send_request(MODE_TO_POLAR, 16'sd1, 16'sd0);
    send_request(MODE_TO_POLAR, 16'sd0, 16'sh7FFF);
    send_request(MODE_TO_POLAR, 16'sd0, 16'sh8000);
    send_request(MODE_TO_POLAR, 16'sh7FFF, 16'sh7FFF);
    send_request(MODE_TO_POLAR, 16'sh8000, 16'sh8000);
    send_request(MODE_TO_POLAR, 16'sh8000, 16'sh7FFF);
    send_request(MODE_TO_POLAR, -16'sd1, -16'sd1);
    send_request(MODE_TO_POLAR, -16'sd5, 16'sd0);
    // Polar to rectangular: quarter-turn boundaries, minus pi and negative radii.
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'sd0);
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'sh8000);
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'sh7FFF);
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'sh4000);
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'sh4001);
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'shC000);
    send_request(MODE_TO_RECT, 16'sh7FFF, 16'shBFFF);
    send_request(MODE_TO_RECT, 16'sh8000, 16'sd12345);
    send_request(MODE_TO_RECT, 16'sh8000, 16'sh8000);
    send_request(MODE_TO_RECT, 16'sd0, 16'sd1000);
    send_request(MODE_TO_RECT, -16'sd1, 16'sh2000);
  endtask

  initial begin
    int steady_start;
    req_if.valid = 1'b0;
    req_if.mode = MODE_TO_POLAR;
    req_if.x_or_radius = '0;
    req_if.y_or_angle = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_directed();

    steady_start = $urandom_range(400, 600);
    for (int n = sb.accepted; n < NUM_ITEMS; n++) begin
      steady = (n >= steady_start && n < steady_start + 200);
      // Once, let the pipeline drain completely before going on.
      if (n == 850) begin
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      maybe_idle();
      if ($urandom_range(0, 1)) send_request(MODE_TO_RECT, pick_coord(), pick_angle());
      else send_request(MODE_TO_POLAR, pick_coord(), pick_coord());
    end
    req_if.valid = 1'b0;
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Checked %0d rectangular-to-polar and %0d polar-to-rectangular conversions,",
             sb.checked_polar, sb.checked_rect);
    $display("with random stalls on both sides, one long output hold-off and one drain pause.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
